/* design/baro_pressure_temp_compensation_defines.svh */
// assertion macros for the barometer compensation block
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH

`ifndef ASSERT_OFF
// clocked check, switched off while reset is held
`define BARO_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds while reset is held
`define BARO_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BARO_ASSERT(lbl, clk, rst_n, prop, msg)
`define BARO_ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

/* design/baro_pkg.sv */
// types and constants of the barometer compensation block
`default_nettype none

package baro_pkg;

  // input word: one raw pressure and one raw temperature conversion
  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } in_word_t;

  // output word: compensated temperature and pressure
  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [16:0]        pressure_centi_mbar;
    logic               saturated;
  } out_word_t;

  // configuration register indices
  typedef enum logic [2:0] {
    CFG_PRESSURE_SENS     = 3'd0,
    CFG_PRESSURE_OFFSET   = 3'd1,
    CFG_SENS_TEMP_COEFF   = 3'd2,
    CFG_OFFSET_TEMP_COEFF = 3'd3,
    CFG_REF_TEMPERATURE   = 3'd4,
    CFG_TEMP_SENSITIVITY  = 3'd5,
    CFG_SECOND_ORDER_EN   = 3'd6
  } cfg_idx_e;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  // temperature thresholds, hundredths of a degree
  localparam logic signed [18:0] TEMP_REF = 19'sd2000;
  localparam logic signed [18:0] TEMP_LOW = -19'sd1500;

  // output ranges
  localparam logic signed [14:0] TEMP_MIN = -15'sd4000;
  localparam logic signed [14:0] TEMP_MAX = 15'sd8500;
  localparam logic [16:0]        PRES_MIN = 17'd1000;
  localparam logic [16:0]        PRES_MAX = 17'd120000;

endpackage

`default_nettype wire

/* design/baro_pressure_temp_compensation.sv */
// Pressure/temperature compensation block, eleven-stage pipeline.
// Usage:
//  - Input channel in_valid_i / in_stall_o carries one word with a raw 24-bit pressure
//    and a raw 24-bit temperature conversion. A word is taken at a rising edge with
//    in_valid_i high and in_stall_o low.
//  - Output channel out_valid_o / out_stall_i returns one word per input word, in order:
//    temperature in hundredths of a degree, pressure in hundredths of a millibar, and a
//    flag set when either value was clipped to its range.
//  - Calibration words and the second-order enable are written through cfg_valid_i /
//    cfg_ready_o with cfg_index_i and cfg_data_i; cfg_ready_o is always high. Write only
//    while no word is in flight.
//  - One word enters per cycle while the output word is not stalled; the rate is set by
//    the pipeline, whose longest stages hold one 25x25 or 24x20 multiplier.
//  - Reset clears all stage valid bits, the calibration words to zero and sets the
//    second-order enable.
//  - While the output word is stalled the whole pipeline holds and in_stall_o is high;
//    nothing is lost or repeated.
`default_nettype none

`include "baro_pressure_temp_compensation_defines.svh"

module baro_pressure_temp_compensation (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // input word channel
  input  wire logic                                in_valid_i,
  output      logic                                in_stall_o,
  input  wire baro_pkg::in_word_t                  in_word_i,
  // output word channel
  output      logic                                out_valid_o,
  input  wire logic                                out_stall_i,
  output      baro_pkg::out_word_t                 out_word_o,
  // configuration write channel
  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [baro_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  wire logic [baro_pkg::CfgDataWidth-1:0]   cfg_data_i
);

  localparam int unsigned NumStages = 11;

  // calibration registers
  logic [15:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
  logic        second_order_en_q;

  // pipeline control
  logic                 adv;
  logic [NumStages-1:0] vld_q;

  // stage 1: dT
  logic signed [24:0] s1_dt_d, s1_dt_q;
  logic [23:0]        s1_d1_q;
  // stage 2: products of dT
  logic signed [40:0] s2_p6_d, s2_p4_d, s2_p3_d;
  logic signed [40:0] s2_p6_q, s2_p4_q, s2_p3_q;
  logic signed [49:0] s2_sq_full;
  logic [16:0]        s2_t2_d, s2_t2_q;
  logic [23:0]        s2_d1_q;
  // stage 3: first-order terms
  logic               s3_c6, s3_c4, s3_c3;
  logic signed [18:0] s3_temp1_d, s3_temp1_q;
  logic signed [34:0] s3_off1_d, s3_off1_q;
  logic signed [33:0] s3_sens1_d, s3_sens1_q;
  logic [16:0]        s3_t2_q;
  logic [23:0]        s3_d1_q;
  // stage 4: squares for the low-temperature correction
  logic signed [18:0] s4_tm, s4_tp;
  logic signed [37:0] s4_sqm_full, s4_sqp_full;
  logic [33:0]        s4_sqm_q, s4_sqp_q;
  logic               s4_apply_d, s4_low_d, s4_apply_q, s4_low_q;
  logic signed [18:0] s4_temp1_q;
  logic signed [34:0] s4_off1_q;
  logic signed [33:0] s4_sens1_q;
  logic [16:0]        s4_t2_q;
  logic [23:0]        s4_d1_q;
  // stage 5: scaled squares, corrected temperature
  logic [36:0]        s5_m5_d, s5_p7_d, s5_m5_q, s5_p7_q;
  logic [37:0]        s5_p11_d, s5_p11_q;
  logic signed [18:0] s5_temp2_d, s5_temp2_q;
  logic signed [34:0] s5_off1_q;
  logic signed [33:0] s5_sens1_q;
  logic [23:0]        s5_d1_q;
  // stage 6: final offset and sensitivity, clipped temperature
  logic signed [38:0] s6_off_d, s6_sens_d, s6_off_q, s6_sens_q;
  logic signed [14:0] s6_tcent_d, s6_tcent_q;
  logic               s6_tclip_d, s6_tclip_q;
  logic [23:0]        s6_d1_q;
  // stage 7: partial products of D1 * SENS
  logic [43:0]        s7_lo_d, s7_lo_q;
  logic signed [43:0] s7_hi_full;
  logic signed [42:0] s7_hi_q;
  logic signed [38:0] s7_off_q;
  logic signed [14:0] s7_tcent_q;
  logic               s7_tclip_q;
  // stage 8: full product
  logic signed [62:0] s8_prod_d, s8_prod_q;
  logic signed [38:0] s8_off_q;
  logic signed [14:0] s8_tcent_q;
  logic               s8_tclip_q;
  // stage 9: product scaled by 2^-21
  logic               s9_corr;
  logic signed [41:0] s9_q_d, s9_q_q;
  logic signed [38:0] s9_off_q;
  logic signed [14:0] s9_tcent_q;
  logic               s9_tclip_q;
  // stage 10: offset removed
  logic signed [42:0] s10_diff_d, s10_diff_q;
  logic signed [14:0] s10_tcent_q;
  logic               s10_tclip_q;
  // stage 11: pressure scaled and clipped
  logic                s11_corr;
  logic signed [27:0]  s11_p;
  baro_pkg::out_word_t out_word_d, out_word_q;

  // terms for the checks
  logic in_take, out_temp_ok, out_pres_ok;

  // handshakes
  assign adv         = !(vld_q[NumStages-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[NumStages-1];
  assign out_word_o  = out_word_q;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q              <= '0;
      c2_q              <= '0;
      c3_q              <= '0;
      c4_q              <= '0;
      c5_q              <= '0;
      c6_q              <= '0;
      second_order_en_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (baro_pkg::cfg_idx_e'(cfg_index_i))
        baro_pkg::CFG_PRESSURE_SENS:     c1_q <= cfg_data_i;
        baro_pkg::CFG_PRESSURE_OFFSET:   c2_q <= cfg_data_i;
        baro_pkg::CFG_SENS_TEMP_COEFF:   c3_q <= cfg_data_i;
        baro_pkg::CFG_OFFSET_TEMP_COEFF: c4_q <= cfg_data_i;
        baro_pkg::CFG_REF_TEMPERATURE:   c5_q <= cfg_data_i;
        baro_pkg::CFG_TEMP_SENSITIVITY:  c6_q <= cfg_data_i;
        baro_pkg::CFG_SECOND_ORDER_EN:   second_order_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  // datapath next values
  always_comb begin
    // dT = D2 - C5 * 2^8
    s1_dt_d = $signed({1'b0, in_word_i.raw_temperature}) - $signed({1'b0, c5_q, 8'd0});

    // products of dT with the calibration words, and dT squared
    s2_p6_d    = 41'(s1_dt_q * $signed({1'b0, c6_q}));
    s2_p4_d    = 41'(s1_dt_q * $signed({1'b0, c4_q}));
    s2_p3_d    = 41'(s1_dt_q * $signed({1'b0, c3_q}));
    s2_sq_full = s1_dt_q * s1_dt_q;
    s2_t2_d    = s2_sq_full[47:31];

    // first-order terms, shifts rounded toward zero
    s3_c6      = s2_p6_q[40] && (|s2_p6_q[22:0]);
    s3_c4      = s2_p4_q[40] && (|s2_p4_q[6:0]);
    s3_c3      = s2_p3_q[40] && (|s2_p3_q[7:0]);
    s3_temp1_d = 19'(s2_p6_q >>> 23) + baro_pkg::TEMP_REF + 19'(s3_c6);
    s3_off1_d  = 35'({c2_q, 16'd0}) + 35'(s2_p4_q >>> 7) + 35'(s3_c4);
    s3_sens1_d = 34'({c1_q, 15'd0}) + 34'(s2_p3_q >>> 8) + 34'(s3_c3);

    // squared distances from the correction thresholds
    s4_tm       = s3_temp1_q - baro_pkg::TEMP_REF;
    s4_tp       = s3_temp1_q - baro_pkg::TEMP_LOW;
    s4_sqm_full = s4_tm * s4_tm;
    s4_sqp_full = s4_tp * s4_tp;
    s4_apply_d  = second_order_en_q && (s3_temp1_q < baro_pkg::TEMP_REF);
    s4_low_d    = s3_temp1_q < baro_pkg::TEMP_LOW;

    // scaled squares, gated by the correction conditions
    s5_m5_d  = s4_apply_q ? (37'(s4_sqm_q) + (37'(s4_sqm_q) << 2)) : '0;
    s5_p7_d  = (s4_apply_q && s4_low_q) ? ((37'(s4_sqp_q) << 3) - 37'(s4_sqp_q)) : '0;
    s5_p11_d = (s4_apply_q && s4_low_q) ?
               ((38'(s4_sqp_q) << 3) + (38'(s4_sqp_q) << 1) + 38'(s4_sqp_q)) : '0;
    s5_temp2_d = s4_apply_q ? (s4_temp1_q - $signed(19'(s4_t2_q))) : s4_temp1_q;

    // final offset and sensitivity
    s6_off_d  = 39'(s5_off1_q) - 39'(s5_m5_q >> 1) - 39'(s5_p7_q);
    s6_sens_d = 39'(s5_sens1_q) - 39'(s5_m5_q >> 2) - 39'(s5_p11_q >> 1);

    // clip temperature
    s6_tclip_d = 1'b1;
    if (s5_temp2_q < 19'(baro_pkg::TEMP_MIN)) begin
      s6_tcent_d = baro_pkg::TEMP_MIN;
    end else if (s5_temp2_q > 19'(baro_pkg::TEMP_MAX)) begin
      s6_tcent_d = baro_pkg::TEMP_MAX;
    end else begin
      s6_tcent_d = s5_temp2_q[14:0];
      s6_tclip_d = 1'b0;
    end

    // D1 * SENS split at bit 20 of SENS
    s7_lo_d    = s6_d1_q * s6_sens_q[19:0];
    s7_hi_full = $signed({1'b0, s6_d1_q}) * $signed(s6_sens_q[38:20]);

    // recombine partial products
    s8_prod_d = (63'(s7_hi_q) <<< 20) + 63'(s7_lo_q);

    // divide by 2^21 toward zero
    s9_corr = s8_prod_q[62] && (|s8_prod_q[20:0]);
    s9_q_d  = 42'(s8_prod_q >>> 21) + 42'(s9_corr);

    // remove offset
    s10_diff_d = 43'(s9_q_q) - 43'(s9_off_q);

    // divide by 2^15 toward zero and clip pressure
    s11_corr = s10_diff_q[42] && (|s10_diff_q[14:0]);
    s11_p    = 28'(s10_diff_q >>> 15) + 28'(s11_corr);
    out_word_d.temperature_centi = s10_tcent_q;
    out_word_d.saturated         = 1'b1;
    if (s11_p < $signed(28'(baro_pkg::PRES_MIN))) begin
      out_word_d.pressure_centi_mbar = baro_pkg::PRES_MIN;
    end else if (s11_p > $signed(28'(baro_pkg::PRES_MAX))) begin
      out_word_d.pressure_centi_mbar = baro_pkg::PRES_MAX;
    end else begin
      out_word_d.pressure_centi_mbar = s11_p[16:0];
      out_word_d.saturated           = s10_tclip_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_dt_q     <= s1_dt_d;
      s1_d1_q     <= in_word_i.raw_pressure;

      s2_p6_q     <= s2_p6_d;
      s2_p4_q     <= s2_p4_d;
      s2_p3_q     <= s2_p3_d;
      s2_t2_q     <= s2_t2_d;
      s2_d1_q     <= s1_d1_q;

      s3_temp1_q  <= s3_temp1_d;
      s3_off1_q   <= s3_off1_d;
      s3_sens1_q  <= s3_sens1_d;
      s3_t2_q     <= s2_t2_q;
      s3_d1_q     <= s2_d1_q;

      s4_sqm_q    <= s4_sqm_full[33:0];
      s4_sqp_q    <= s4_sqp_full[33:0];
      s4_apply_q  <= s4_apply_d;
      s4_low_q    <= s4_low_d;
      s4_temp1_q  <= s3_temp1_q;
      s4_off1_q   <= s3_off1_q;
      s4_sens1_q  <= s3_sens1_q;
      s4_t2_q     <= s3_t2_q;
      s4_d1_q     <= s3_d1_q;

      s5_m5_q     <= s5_m5_d;
      s5_p7_q     <= s5_p7_d;
      s5_p11_q    <= s5_p11_d;
      s5_temp2_q  <= s5_temp2_d;
      s5_off1_q   <= s4_off1_q;
      s5_sens1_q  <= s4_sens1_q;
      s5_d1_q     <= s4_d1_q;

      s6_off_q    <= s6_off_d;
      s6_sens_q   <= s6_sens_d;
      s6_tcent_q  <= s6_tcent_d;
      s6_tclip_q  <= s6_tclip_d;
      s6_d1_q     <= s5_d1_q;

      s7_lo_q     <= s7_lo_d;
      s7_hi_q     <= s7_hi_full[42:0];
      s7_off_q    <= s6_off_q;
      s7_tcent_q  <= s6_tcent_q;
      s7_tclip_q  <= s6_tclip_q;

      s8_prod_q   <= s8_prod_d;
      s8_off_q    <= s7_off_q;
      s8_tcent_q  <= s7_tcent_q;
      s8_tclip_q  <= s7_tclip_q;

      s9_q_q      <= s9_q_d;
      s9_off_q    <= s8_off_q;
      s9_tcent_q  <= s8_tcent_q;
      s9_tclip_q  <= s8_tclip_q;

      s10_diff_q  <= s10_diff_d;
      s10_tcent_q <= s9_tcent_q;
      s10_tclip_q <= s9_tclip_q;

      out_word_q  <= out_word_d;
    end
  end

  // checks
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_temp_ok = (out_word_o.temperature_centi >= baro_pkg::TEMP_MIN) &&
                       (out_word_o.temperature_centi <= baro_pkg::TEMP_MAX);
  assign out_pres_ok = (out_word_o.pressure_centi_mbar >= baro_pkg::PRES_MIN) &&
                       (out_word_o.pressure_centi_mbar <= baro_pkg::PRES_MAX);

  `BARO_ASSERT_RST(a_rst_clears, clk_i, !rst_ni |=> (vld_q == '0), "valid bits not cleared")
  `BARO_ASSERT(a_accept_enters, clk_i, rst_ni, in_take |=> vld_q[0], "accepted word lost")
  `BARO_ASSERT(a_hold_on_stall, clk_i, rst_ni, !adv |=> $stable(vld_q), "moved while stalled")
  `BARO_ASSERT(a_temp_range, clk_i, rst_ni, out_valid_o |-> out_temp_ok, "temp out of range")
  `BARO_ASSERT(a_pres_range, clk_i, rst_ni, out_valid_o |-> out_pres_ok, "pres out of range")

endmodule

`default_nettype wire

/* tb/tb_baro_pressure_temp_compensation.sv */
// self-checking testbench for the barometer pressure/temperature compensation block
module tb_baro_pressure_temp_compensation;
  timeunit 1ns;
  timeprecision 1ps;

  // pipeline depth from input acceptance to output word
  localparam int LATENCY = 11;
  // write to an index with no register behind it
  localparam logic [baro_pkg::CfgIdxWidth-1:0] CFG_IDX_UNUSED = 3'd7;
  localparam int N_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 190;

  typedef logic [baro_pkg::CfgDataWidth-1:0] coef_set_t [0:5];

  // receiver stall patterns
  typedef enum int {
    RX_NEVER,
    RX_RANDOM,
    RX_HEAVY,
    RX_PERIODIC
  } rx_style_e;

  logic                              clk       = 1'b0;
  logic                              rst_n     = 1'b0;
  logic                              in_valid  = 1'b0;
  baro_pkg::in_word_t                in_word   = '0;
  logic                              out_stall = 1'b0;
  logic                              cfg_valid = 1'b0;
  logic [baro_pkg::CfgIdxWidth-1:0]  cfg_index = '0;
  logic [baro_pkg::CfgDataWidth-1:0] cfg_data  = '0;
  logic                              in_stall;
  logic                              out_valid;
  baro_pkg::out_word_t               out_word;
  logic                              cfg_ready;

  // calibration as the testbench believes it to be
  logic [baro_pkg::CfgDataWidth-1:0] cal_coef [0:5] = '{default: '0};
  logic                              cal_second_order = 1'b1;

  baro_pkg::out_word_t expected_words [$];

  // sender pacing and receiver pattern
  bit        gaps_on    = 1'b1;
  int        burst_left = 4;
  rx_style_e rx_style   = RX_RANDOM;
  int        hold_req   = 0;
  int        hold_cnt   = 0;
  int        rx_cycle   = 0;

  // bookkeeping
  int n_errors    = 0;
  int n_accepted  = 0;
  int n_checked   = 0;
  int n_settings  = 0;
  int n_corrected = 0;
  int n_cold      = 0;
  int n_clipped   = 0;

  baro_pressure_temp_compensation u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // compensated temperature and pressure for one raw conversion pair
  function automatic baro_pkg::out_word_t compensate(baro_pkg::in_word_t w);
    longint d1, d2, dt, t_c, off, sens, t2, off2, sens2, sq_ref, sq_cold, p;
    logic   clip;
    baro_pkg::out_word_t r;
    d1   = longint'(w.raw_pressure);
    d2   = longint'(w.raw_temperature);
    dt   = d2 - longint'(cal_coef[baro_pkg::CFG_REF_TEMPERATURE]) * 256;
    t_c  = baro_pkg::TEMP_REF
         + (dt * longint'(cal_coef[baro_pkg::CFG_TEMP_SENSITIVITY])) / 8388608;
    off  = longint'(cal_coef[baro_pkg::CFG_PRESSURE_OFFSET]) * 65536
         + (dt * longint'(cal_coef[baro_pkg::CFG_OFFSET_TEMP_COEFF])) / 128;
    sens = longint'(cal_coef[baro_pkg::CFG_PRESSURE_SENS]) * 32768
         + (dt * longint'(cal_coef[baro_pkg::CFG_SENS_TEMP_COEFF])) / 256;
    // low-temperature correction, terms taken from the uncorrected temperature
    if (cal_second_order && t_c < baro_pkg::TEMP_REF) begin
      n_corrected++;
      t2     = (dt * dt) / 64'sd2147483648;
      sq_ref = (t_c - baro_pkg::TEMP_REF) * (t_c - baro_pkg::TEMP_REF);
      off2   = (5 * sq_ref) / 2;
      sens2  = (5 * sq_ref) / 4;
      if (t_c < baro_pkg::TEMP_LOW) begin
        n_cold++;
        sq_cold = (t_c - baro_pkg::TEMP_LOW) * (t_c - baro_pkg::TEMP_LOW);
        off2    = off2 + 7 * sq_cold;
        sens2   = sens2 + (11 * sq_cold) / 2;
      end
      t_c  = t_c - t2;
      off  = off - off2;
      sens = sens - sens2;
    end
    p = ((d1 * sens) / 2097152 - off) / 32768;
    // clip to output ranges
    clip = 1'b0;
    if (t_c < baro_pkg::TEMP_MIN) begin
      t_c  = baro_pkg::TEMP_MIN;
      clip = 1'b1;
    end
    if (t_c > baro_pkg::TEMP_MAX) begin
      t_c  = baro_pkg::TEMP_MAX;
      clip = 1'b1;
    end
    if (p < longint'(baro_pkg::PRES_MIN)) begin
      p    = longint'(baro_pkg::PRES_MIN);
      clip = 1'b1;
    end
    if (p > longint'(baro_pkg::PRES_MAX)) begin
      p    = longint'(baro_pkg::PRES_MAX);
      clip = 1'b1;
    end
    if (clip) n_clipped++;
    r.temperature_centi   = t_c[14:0];
    r.pressure_centi_mbar = p[16:0];
    r.saturated           = clip;
    return r;
  endfunction

  // offer one word and hold it until taken; valid stays high on return
  task automatic send_sample(baro_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    expected_words.push_back(compensate(w));
    n_accepted++;
  endtask

  // sender bursts with random gaps between them
  task automatic pace();
    int gap;
    if (!gaps_on) return;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
  endtask

  task automatic send_paced(baro_pkg::in_word_t w);
    send_sample(w);
    pace();
  endtask

  // stop offering, let every result come back and the pipeline empty
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // one register write; valid is left high for a following write
  task automatic write_reg(logic [baro_pkg::CfgIdxWidth-1:0] idx,
                           logic [baro_pkg::CfgDataWidth-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      baro_pkg::CFG_SECOND_ORDER_EN: cal_second_order = data[0];
      CFG_IDX_UNUSED:                ;
      default:                       cal_coef[idx] = data;
    endcase
  endtask

  // load a full calibration set while the block is idle
  task automatic set_calibration(coef_set_t c, logic so_en);
    wait_results_done();
    for (int i = 0; i < 6; i++) write_reg(baro_pkg::cfg_idx_e'(i), c[i]);
    write_reg(baro_pkg::CFG_SECOND_ORDER_EN, {15'd0, so_en});
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  function automatic coef_set_t typical_coefs();
    coef_set_t c;
    c = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
    return c;
  endfunction

  // typical set with each word moved by up to about an eighth
  function automatic coef_set_t jittered_coefs();
    coef_set_t c;
    int v;
    c = typical_coefs();
    for (int i = 0; i < 6; i++) begin
      v = int'(c[i]);
      v = v + int'($urandom_range(0, v / 4)) - v / 8;
      c[i] = v[15:0];
    end
    return c;
  endfunction

  function automatic baro_pkg::in_word_t make_word(longint d1, longint d2);
    baro_pkg::in_word_t w;
    if (d1 < 0) d1 = 0;
    if (d1 > 24'hFFFFFF) d1 = 24'hFFFFFF;
    if (d2 < 0) d2 = 0;
    if (d2 > 24'hFFFFFF) d2 = 24'hFFFFFF;
    w.raw_pressure    = d1[23:0];
    w.raw_temperature = d2[23:0];
    return w;
  endfunction

  // mostly plausible conversions around the reference temperature, some raw noise
  function automatic baro_pkg::in_word_t random_word();
    longint d1, d2;
    if ($urandom_range(0, 4) == 0) begin
      d1 = longint'($urandom_range(0, 24'hFFFFFF));
      d2 = longint'($urandom_range(0, 24'hFFFFFF));
    end else begin
      d1 = longint'($urandom_range(2_000_000, 12_000_000));
      d2 = longint'(cal_coef[baro_pkg::CFG_REF_TEMPERATURE]) * 256
         + longint'($urandom_range(0, 5_000_000)) - 3_000_000;
    end
    return make_word(d1, d2);
  endfunction

  // receiver stall pattern, with long hold-offs counted here
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      case (rx_style)
        RX_NEVER:    out_stall <= 1'b0;
        RX_RANDOM:   out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: out_stall <= ((rx_cycle % 9) < 4);
        default:     out_stall <= 1'b0;
      endcase
    end
  end

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      n_errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // compare each taken output word with the oldest prediction
  always @(posedge clk) begin
    baro_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        n_errors++;
        $display("%0t ns: unexpected word, expected none, actual temp %0d pres %0d sat %0b",
                 $time, out_word.temperature_centi, out_word.pressure_centi_mbar,
                 out_word.saturated);
      end else begin
        want = expected_words.pop_front();
        n_checked++;
        check_field("temperature_centi", want.temperature_centi,
                    out_word.temperature_centi);
        check_field("pressure_centi_mbar", want.pressure_centi_mbar,
                    out_word.pressure_centi_mbar);
        check_field("saturated", want.saturated, out_word.saturated);
      end
    end
  end

  // reset calibration: all words zero, so pressure clips low
  task automatic test_reset_state();
    send_paced(make_word(0, 0));
    send_paced(make_word(24'hFFFFFF, 24'hFFFFFF));
    send_paced(make_word(24'h800000, 24'h7FFFFF));
  endtask

  // every register, an unused index, and an enable word with only upper bits set
  task automatic test_register_map();
    baro_pkg::in_word_t w;
    w = make_word(9085466, 8569150);
    set_calibration(typical_coefs(), 1'b1);
    write_reg(CFG_IDX_UNUSED, 16'hFFFF);
    write_reg(baro_pkg::CFG_SECOND_ORDER_EN, 16'hFFFE);
    cfg_valid <= 1'b0;
    send_paced(w);
    send_paced(make_word(9085466, 8000000));
    wait_results_done();
    write_reg(baro_pkg::CFG_SECOND_ORDER_EN, 16'h0001);
    cfg_valid <= 1'b0;
    send_paced(make_word(9085466, 8000000));
  endtask

  // above 20 C, exactly 20 C, just below, below -15 C, and both clip bounds
  task automatic test_temperature_bands();
    longint dts [8] = '{0, -300, 1000, -500000, -1050000, -1200000, 2000000, -2500000};
    longint base;
    set_calibration(typical_coefs(), 1'b1);
    base = longint'(cal_coef[baro_pkg::CFG_REF_TEMPERATURE]) * 256;
    foreach (dts[i]) send_paced(make_word(9085466, base + dts[i]));
    send_paced(make_word(0, base));
    send_paced(make_word(24'hFFFFFF, base));
  endtask

  // calibration words at both ends of their range
  task automatic test_coefficient_extremes();
    coef_set_t c;
    c = '{default: 16'hFFFF};
    set_calibration(c, 1'b1);
    send_paced(make_word(0, 0));
    send_paced(make_word(24'hFFFFFF, 24'hFFFFFF));
    send_paced(make_word(24'hFFFFFF, 0));
    send_paced(make_word(0, 24'hFFFFFF));
    c = '{default: 16'h0000};
    set_calibration(c, 1'b0);
    send_paced(make_word(24'hFFFFFF, 0));
    send_paced(make_word(24'h5A5A5A, 24'hA5A5A5));
  endtask

  // long receiver hold-off while words keep coming, so the input stalls
  task automatic test_output_holdoff();
    set_calibration(typical_coefs(), 1'b1);
    gaps_on  = 1'b0;
    hold_req = 200;
    repeat (60) send_paced(random_word());
    wait_results_done();
    gaps_on  = 1'b1;
  endtask

  // random words under a series of calibrations and pacing patterns
  task automatic test_random_phases();
    coef_set_t c;
    logic so_en;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      so_en = 1'($urandom_range(0, 1));
      case (ph)
        0: c = typical_coefs();
        1: c = '{default: 16'hFFFF};
        2: c = '{default: 16'h0000};
        3, 4: begin
          for (int i = 0; i < 6; i++) c[i] = 16'($urandom_range(0, 16'hFFFF));
        end
        default: c = jittered_coefs();
      endcase
      if (ph == 0 || ph == 1) so_en = 1'b1;
      if (ph == 2) so_en = 1'b0;
      set_calibration(c, so_en);
      rx_style = rx_style_e'(ph % 4);
      gaps_on  = (ph % 3 != 2);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_paced(random_word());
        // mid-phase pause until the block has returned everything
        if (ph == 5 && k == ITEMS_PER_PHASE / 2) wait_results_done();
      end
    end
    rx_style = RX_RANDOM;
    gaps_on  = 1'b1;
  endtask

  // test sequence
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_register_map();
    test_temperature_bands();
    test_coefficient_extremes();
    test_output_holdoff();
    test_random_phases();
    wait_results_done();
    $display("checked %0d of %0d words over %0d calibration settings",
             n_checked, n_accepted, n_settings);
    $display("low-temperature correction on %0d words, extra cold term on %0d, %0d clipped",
             n_corrected, n_cold, n_clipped);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d words outstanding", expected_words.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/baro_pkg.sv
design/baro_pressure_temp_compensation.sv
tb/tb_baro_pressure_temp_compensation.sv
